/* design/fenw_pkg.sv */
package fenw_pkg;

	// Tree geometry
	localparam int TREE_SIZE = 1024;
	localparam int IDX_W     = $clog2(TREE_SIZE);
	localparam int POS_W     = 10;
	localparam int SUM_W     = 32;
	localparam int CMP_W     = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SUM_W-1:0] sum_t;

	localparam idx_t             IDX_LAST = idx_t'(TREE_SIZE - 1);
	localparam logic [IDX_W:0]   SIZE_EXT = (IDX_W + 1)'(TREE_SIZE);
	localparam logic [CMP_W-1:0] SIZE_CMP = CMP_W'(TREE_SIZE);
	localparam sum_t             SUM_ONE  = sum_t'(1);

	// Item modes
	localparam logic MODE_INC = 1'b0;
	localparam logic MODE_QRY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INC,
		ST_QRY,
		ST_DONE
	} state_t;

	// Memory access issued by the controller
	typedef struct packed {
		logic wr_en;
		idx_t wr_addr;
		sum_t wr_data;
		idx_t rd_addr;
	} mem_cmd_t;

endpackage

/* design/fenwick_tree_count_engine.sv */
// Channel   Handshake             Payload
// input     in_valid / in_ready   mode, position
// output    out_valid / out_ready prefix_sum
//
// Reset clears the counter memory one entry a cycle; no item is taken until it is done.
// An increment or a query walks the tree nodes on the path of its position
// (at most 11 for an increment, 10 for a query), reading each node from the
// counter memory; an increment writes each node back while it reads the next.
// A query result waits in the output register, increments going on meanwhile;
// a following query holds in its last state until that register is free.
module fenwick_tree_count_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [fenw_pkg::POS_W-1:0] position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [fenw_pkg::SUM_W-1:0] prefix_sum
);

	import fenw_pkg::*;

	mem_cmd_t mem_cmd;
	sum_t     rd_data;

	fenw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prefix_sum (prefix_sum),
		.mem_cmd    (mem_cmd),
		.rd_data    (rd_data)
	);

	// Tree counters
	fenw_ram #(
		.WIDTH (SUM_W),
		.DEPTH (TREE_SIZE)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_cmd.wr_en),
		.wr_addr (mem_cmd.wr_addr),
		.wr_data (mem_cmd.wr_data),
		.rd_addr (mem_cmd.rd_addr),
		.rd_data (rd_data)
	);

	// No write happens while an item can be taken
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !mem_cmd.wr_en)
		else $error("memory write while idle");

	// Below the top node, an increment write-back never hits the node read next
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_cmd.wr_en && mem_cmd.wr_data != '0 && mem_cmd.wr_addr != IDX_LAST)
		|-> (mem_cmd.rd_addr != mem_cmd.wr_addr))
		else $error("read and write-back collide on one node");

	// A query always starts a walk, so the input closes next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode == MODE_QRY) |=> !in_ready)
		else $error("query accepted without a walk");

endmodule

/* design/fenw_ram.sv */
module fenw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* design/fenw_ctrl.sv */
module fenw_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       mode,
	input  logic [fenw_pkg::POS_W-1:0] position,
	output logic                       out_valid,
	input  logic                       out_ready,
	output fenw_pkg::sum_t             prefix_sum,
	output fenw_pkg::mem_cmd_t         mem_cmd,
	input  fenw_pkg::sum_t             rd_data
);

	import fenw_pkg::*;

	state_t           state_q, state_nxt;
	idx_t             node_q;
	idx_t             clr_q;
	sum_t             acc_q;
	sum_t             prefix_sum_q;
	logic             out_valid_q;
	logic             accept;
	logic             out_free;
	logic [CMP_W-1:0] pos_ext;
	logic             pos_in_range;
	idx_t             pos_sat;
	logic [IDX_W:0]   node_ext;
	logic [IDX_W:0]   inc_nxt;
	logic             inc_more;
	idx_t             qry_base;
	idx_t             qry_prev;
	logic             qry_more;
	sum_t             sum_now;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Position clamp: a query past the end reads the whole tree
	assign pos_ext      = CMP_W'(position);
	assign pos_in_range = pos_ext < SIZE_CMP;
	assign pos_sat      = pos_in_range ? pos_ext[IDX_W-1:0] : IDX_LAST;

	// Upward step for increments: p | (p + 1)
	assign node_ext = {1'b0, node_q};
	assign inc_nxt  = node_ext | (node_ext + 1'b1);
	assign inc_more = inc_nxt < SIZE_EXT;

	// Downward step for queries: (p & (p + 1)) - 1
	assign qry_base = node_q & (node_q + 1'b1);
	assign qry_more = qry_base != '0;
	assign qry_prev = qry_base - 1'b1;

	assign sum_now = acc_q + rd_data;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_LAST) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_QRY) begin
						state_nxt = ST_QRY;
					end else if (pos_in_range) begin
						state_nxt = ST_INC;
					end
				end
			end
			ST_INC: begin
				if (!inc_more) state_nxt = ST_IDLE;
			end
			ST_QRY: begin
				if (!qry_more) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// Memory commands and handshake
	always_comb begin
		in_ready        = 1'b0;
		mem_cmd.wr_en   = 1'b0;
		mem_cmd.wr_addr = node_q;
		mem_cmd.wr_data = '0;
		mem_cmd.rd_addr = node_q;
		case (state_q)
			ST_CLEAR: begin
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_addr = clr_q;
			end
			ST_IDLE: begin
				in_ready        = 1'b1;
				mem_cmd.rd_addr = pos_sat;
			end
			ST_INC: begin
				// write back this node while reading the next one up
				mem_cmd.wr_en   = 1'b1;
				mem_cmd.wr_data = rd_data + SUM_ONE;
				mem_cmd.rd_addr = inc_nxt[IDX_W-1:0];
			end
			ST_QRY: begin
				mem_cmd.rd_addr = qry_prev;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk address, accumulator and result register
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				node_q <= pos_sat;
				acc_q  <= '0;
			end
			ST_INC: begin
				node_q <= inc_nxt[IDX_W-1:0];
			end
			ST_QRY: begin
				node_q <= qry_prev;
				acc_q  <= sum_now;
			end
			ST_DONE: begin
				if (out_free) prefix_sum_q <= acc_q;
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign prefix_sum = prefix_sum_q;

endmodule

/* bench/testbench.sv */
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fenw_pkg::*;

	localparam int          CLK_HALF      = 5;
	localparam int          RESET_CYCLES  = 10;
	localparam int          SETTLE_CYCLES = 64;
	localparam int unsigned LONG_HOLD     = 300;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_style_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic             mode      = MODE_INC;
	logic [POS_W-1:0] position  = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [SUM_W-1:0] prefix_sum;

	// Shadow copy of the counter tree and the sums still owed by the block
	sum_t        node_count [TREE_SIZE];
	sum_t        pending_sums [$];
	int unsigned error_count = 0;
	int unsigned hold_len    = 0;
	int unsigned burst_left  = 0;
	bit          gaps_on     = 1'b1;

	fenwick_tree_count_engine u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.position   (position),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prefix_sum (prefix_sum)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Add one on every node whose range covers pos; out-of-range is a no-op
	function automatic void count_increment(input logic [POS_W-1:0] pos);
		int unsigned p;
		p = 32'(pos);
		while (p < TREE_SIZE) begin
			node_count[idx_t'(p)] = node_count[idx_t'(p)] + SUM_ONE;
			p = p | (p + 1);
		end
	endfunction

	// Sum of all increments at positions 0..pos; pos saturates to the last node
	function automatic sum_t count_prefix(input logic [POS_W-1:0] pos);
		int unsigned p;
		int unsigned base;
		sum_t        acc;
		p = (pos >= TREE_SIZE) ? TREE_SIZE - 1 : pos;
		acc = '0;
		base = 1;
		while (base != 0) begin
			acc = acc + node_count[idx_t'(p)];
			base = p & (p + 1);
			p = base - 1;
		end
		return acc;
	endfunction

	// Position mix: ends, power-of-two borders, a dense low corner, and full range
	function automatic logic [POS_W-1:0] pick_position();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return POS_W'((1 << $urandom_range(0, POS_W - 1)) - $urandom_range(0, 1));
			3, 4: return POS_W'($urandom_range(0, 15));
			default: return POS_W'($urandom);
		endcase
	endfunction

	// Offer one item, wait for it to be taken, then update the shadow tree or queue the owed sum
	task automatic send_item(input logic m, input logic [POS_W-1:0] p);
		in_valid <= 1'b1;
		mode <= m;
		position <= p;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (m == MODE_QRY)
			pending_sums.push_back(count_prefix(p));
		else
			count_increment(p);
		// bursty sender: random gap once the current burst is used up
		if (gaps_on) begin
			if (burst_left == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_results_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_sums.size() != 0) @(posedge clk);
	endtask

	// Empty tree, both ends, power-of-two borders, alternating bit patterns
	task automatic test_directed();
		send_item(MODE_QRY, 10'd0);
		send_item(MODE_QRY, 10'd1023);
		send_item(MODE_INC, 10'd0);
		send_item(MODE_INC, 10'd1023);
		send_item(MODE_QRY, 10'd0);
		send_item(MODE_QRY, 10'd1022);
		send_item(MODE_QRY, 10'd1023);
		send_item(MODE_INC, 10'd511);
		send_item(MODE_INC, 10'd512);
		send_item(MODE_QRY, 10'd510);
		send_item(MODE_QRY, 10'd511);
		send_item(MODE_QRY, 10'd512);
		send_item(MODE_INC, 10'd0);
		send_item(MODE_QRY, 10'd0);
		send_item(MODE_INC, 10'd1);
		send_item(MODE_INC, 10'd682);
		send_item(MODE_INC, 10'd341);
		send_item(MODE_QRY, 10'd341);
		send_item(MODE_QRY, 10'd681);
		send_item(MODE_QRY, 10'd682);
		send_item(MODE_QRY, 10'd1023);
		send_item(MODE_QRY, 10'd1);
	endtask

	task automatic test_random_mix();
		repeat (300) send_item(logic'($urandom_range(0, 1)), pick_position());
	endtask

	// Pile increments onto a few positions so node counts grow deep
	task automatic test_hot_spots();
		logic [POS_W-1:0] hot [4];
		foreach (hot[i]) hot[i] = pick_position();
		repeat (120) begin
			if ($urandom_range(0, 9) < 7)
				send_item(MODE_INC, hot[2'($urandom_range(0, 3))]);
			else if ($urandom_range(0, 1) == 0)
				send_item(MODE_QRY, hot[2'($urandom_range(0, 3))]);
			else
				send_item(MODE_QRY, pick_position());
		end
	endtask

	// Receiver holds off while queries keep coming: output fills, input stalls
	task automatic test_output_stall();
		gaps_on = 1'b0;
		hold_len = LONG_HOLD;
		repeat (40) begin
			if ($urandom_range(0, 3) == 0)
				send_item(MODE_INC, pick_position());
			else
				send_item(MODE_QRY, pick_position());
		end
		gaps_on = 1'b1;
	endtask

	// Sender stops until every owed sum has come back, then resumes
	task automatic test_drain_pause();
		repeat (3) begin
			repeat (30) send_item(logic'($urandom_range(0, 1)), pick_position());
			wait_results_drained();
		end
	endtask

	// Back-to-back items with no sender gaps
	task automatic test_streaming();
		gaps_on = 1'b0;
		repeat (80) send_item(logic'($urandom_range(0, 1)), pick_position());
		gaps_on = 1'b1;
	endtask

	// Receiver: changes stall pattern every segment; a requested hold wins
	initial begin
		int unsigned seg_len;
		rx_style_t   style;
		forever begin
			style = rx_style_t'($urandom_range(0, 3));
			seg_len = $urandom_range(16, 160);
			while (seg_len != 0) begin
				@(posedge clk);
				if (hold_len != 0) begin
					out_ready <= 1'b0;
					hold_len--;
				end else begin
					case (style)
						RX_OPEN: out_ready <= 1'b1;
						RX_COIN: out_ready <= logic'($urandom_range(0, 1));
						RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ((seg_len % 8) < 5);
					endcase
				end
				seg_len--;
			end
		end
	end

	// Result check against the oldest owed sum
	always @(posedge clk) begin
		sum_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				$error("prefix_sum: no query outstanding, got %0d", prefix_sum);
				error_count++;
			end else begin
				want = pending_sums.pop_front();
				if (prefix_sum !== want) begin
					$error("prefix_sum: expected %0d, got %0d", want, prefix_sum);
					error_count++;
				end
			end
		end
	end

	initial begin
		foreach (node_count[i]) node_count[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix();
		test_hot_spots();
		test_output_stall();
		test_drain_pause();
		test_streaming();
		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
